// ----- src/pbm_pkg.sv -----
// shared types, constants and helpers for the pbm p4 stream parser
package pbm_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned POS_W    = 12;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned ACC_W    = 17;
  localparam int unsigned ACC_CAP  = 65536;
  localparam int unsigned GROUP_PIX = 8;

  localparam logic [BYTE_W-1:0] CH_P    = 8'h50;
  localparam logic [BYTE_W-1:0] CH_FOUR = 8'h34;
  localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;

  typedef enum logic [3:0] {
    PH_MAGIC_P,
    PH_MAGIC_4,
    PH_SPACE,
    PH_WIDTH,
    PH_HEIGHT,
    PH_RASTER,
    PH_COMMENT
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_PIXELS,
    KIND_ERROR
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_MAGIC,
    ERR_CHAR,
    ERR_DIM
  } err_e;

  typedef struct packed {
    kind_e              kind;
    err_e               error_code;
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic [BYTE_W-1:0]  pixel_bits;
    logic [CNT_W-1:0]   pixel_count;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   column;
    logic               last;
  } res_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] byte_value;
  } byte_beat_t;

  function automatic logic is_ws(input logic [BYTE_W-1:0] b);
    return (b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

// ----- src/pbm_if.sv -----
// byte and result channel interfaces
interface pbm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;

  modport source (output valid, output byte_value, input ready);
  modport sink (input valid, input byte_value, output ready);
endinterface

interface pbm_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  error_code;
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [7:0]  pixel_bits;
  logic [3:0]  pixel_count;
  logic [11:0] row;
  logic [11:0] column;
  logic        last;

  modport source (
    output valid, output kind, output error_code, output image_width,
    output image_height, output pixel_bits, output pixel_count, output row,
    output column, output last, input ready
  );
  modport sink (
    input valid, input kind, input error_code, input image_width,
    input image_height, input pixel_bits, input pixel_count, input row,
    input column, input last, output ready
  );
endinterface

// ----- src/pbm_p4_stream_parser_top.sv -----
// top level of the raw pbm (p4) byte stream parser
// a byte beat is held in the input register, then its result in the result register, which drives res_o
// throughput: one byte per cycle, stalled only by res_o backpressure
// input register, one pass of parse logic, result register
// reset: asynchronous active low, returns to expecting the magic and clears errors
module pbm_p4_stream_parser_top #(
  parameter int unsigned MAX_WIDTH  = pbm_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = pbm_pkg::MAX_HEIGHT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pbm_byte_if.sink  byte_i,
  pbm_res_if.source res_o
);

  pbm_pkg::byte_beat_t beat;
  pbm_pkg::res_t       res_comb;
  pbm_pkg::res_t       res_reg;
  logic                res_valid;
  logic                can_take;
  logic                advance;

  assign advance = beat.valid && can_take;

  pbm_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (byte_i.valid),
    .byte_value_i (byte_i.byte_value),
    .ready_o      (byte_i.ready),
    .advance_i    (advance),
    .beat_o       (beat)
  );

  pbm_parse #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (advance),
    .byte_value_i (beat.byte_value),
    .res_valid_o  (res_valid),
    .res_o        (res_comb)
  );

  pbm_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res_comb),
    .can_take_o  (can_take),
    .valid_o     (res_o.valid),
    .res_o       (res_reg),
    .ready_i     (res_o.ready)
  );

  assign res_o.kind         = res_reg.kind;
  assign res_o.error_code   = res_reg.error_code;
  assign res_o.image_width  = res_reg.image_width;
  assign res_o.image_height = res_reg.image_height;
  assign res_o.pixel_bits   = res_reg.pixel_bits;
  assign res_o.pixel_count  = res_reg.pixel_count;
  assign res_o.row          = res_reg.row;
  assign res_o.column       = res_reg.column;
  assign res_o.last         = res_reg.last;

endmodule

// ----- src/pbm_in_stage.sv -----
// input register holding one byte beat
module pbm_in_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [pbm_pkg::BYTE_W-1:0]    byte_value_i,
  output logic                          ready_o,
  input  logic                          advance_i,
  output pbm_pkg::byte_beat_t           beat_o
);

  logic                       valid_q, valid_d;
  logic [pbm_pkg::BYTE_W-1:0] byte_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_value_i;
    end
  end

  assign beat_o.valid      = valid_q;
  assign beat_o.byte_value = byte_q;

endmodule

// ----- src/pbm_parse.sv -----
// header state machine, dimension check and raster unpacking
module pbm_parse #(
  parameter int unsigned MAX_WIDTH  = pbm_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = pbm_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [pbm_pkg::BYTE_W-1:0] byte_value_i,
  output logic                       res_valid_o,
  output pbm_pkg::res_t              res_o
);

  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned ACC_W = pbm_pkg::ACC_W;
  localparam int unsigned PROD_W = ACC_W + 4;

  pbm_pkg::phase_e    phase_q, phase_d;
  pbm_pkg::phase_e    resume_q, resume_d;
  pbm_pkg::phase_e    after_q, after_d;
  pbm_pkg::phase_e    num_ph;
  logic               seen_q, seen_d;
  logic [ACC_W-1:0]   acc_q, acc_d, acc_in;
  logic               have_q, have_d, have_in;
  logic [WW-1:0]      width_q, width_d;
  logic [HW-1:0]      height_q, height_d;
  logic [HW-1:0]      row_q, row_d;
  logic [WW-1:0]      col_q, col_d;
  logic               fin_q, fin_d;
  logic               err_q, err_d;

  logic [pbm_pkg::BYTE_W-1:0] b;
  logic [PROD_W-1:0]  prod;
  logic [WW-1:0]      left;
  logic [pbm_pkg::CNT_W-1:0] cnt;
  logic [7:0]         mask;
  logic [WW:0]        col_next;
  logic [HW:0]        row_next;
  logic               lst;
  logic [31:0]        w32, h32, r32, c32;

  assign b = byte_value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= pbm_pkg::PH_MAGIC_P;
      resume_q <= pbm_pkg::PH_MAGIC_P;
      after_q  <= pbm_pkg::PH_MAGIC_P;
      seen_q   <= 1'b0;
      acc_q    <= '0;
      have_q   <= 1'b0;
      width_q  <= '0;
      height_q <= '0;
      row_q    <= '0;
      col_q    <= '0;
      fin_q    <= 1'b0;
      err_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      resume_q <= resume_d;
      after_q  <= after_d;
      seen_q   <= seen_d;
      acc_q    <= acc_d;
      have_q   <= have_d;
      width_q  <= width_d;
      height_q <= height_d;
      row_q    <= row_d;
      col_q    <= col_d;
      fin_q    <= fin_d;
      err_q    <= err_d;
    end
  end

  // number entry, either continuing or starting right after whitespace
  assign num_ph  = (phase_q == pbm_pkg::PH_SPACE) ? after_q : phase_q;
  assign acc_in  = (phase_q == pbm_pkg::PH_SPACE) ? '0 : acc_q;
  assign have_in = (phase_q == pbm_pkg::PH_SPACE) ? 1'b0 : have_q;
  assign prod    = {acc_in, 3'b000} + {2'b00, acc_in, 1'b0}
                 + PROD_W'(b - pbm_pkg::CH_ZERO);

  // raster group
  assign left     = (width_q > col_q) ? (width_q - col_q) : WW'(1);
  assign cnt      = (left < WW'(pbm_pkg::GROUP_PIX)) ? pbm_pkg::CNT_W'(left)
                                                     : pbm_pkg::CNT_W'(pbm_pkg::GROUP_PIX);
  assign mask     = 8'(16'hFF00 >> cnt);
  assign col_next = {1'b0, col_q} + (WW + 1)'(cnt);
  assign row_next = {1'b0, row_q} + (HW + 1)'(1);
  assign lst      = (row_next >= {1'b0, height_q}) && (col_next >= {1'b0, width_q});

  assign w32 = 32'(width_q);
  assign h32 = 32'(height_q);
  assign r32 = 32'(row_q);
  assign c32 = 32'(col_q);

  always_comb begin
    phase_d  = phase_q;
    resume_d = resume_q;
    after_d  = after_q;
    seen_d   = seen_q;
    acc_d    = acc_q;
    have_d   = have_q;
    width_d  = width_q;
    height_d = height_q;
    row_d    = row_q;
    col_d    = col_q;
    fin_d    = fin_q;
    err_d    = err_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (fire_i && !err_q && !fin_q) begin
      if ((phase_q != pbm_pkg::PH_RASTER) && (b == pbm_pkg::CH_HASH)) begin
        if (phase_q != pbm_pkg::PH_COMMENT) begin
          resume_d = phase_q;
          phase_d  = pbm_pkg::PH_COMMENT;
        end
      end else begin
        case (phase_q)
          pbm_pkg::PH_COMMENT: begin
            if ((b == pbm_pkg::CH_LF) || (b == pbm_pkg::CH_CR)) begin
              phase_d = resume_q;
            end
          end
          pbm_pkg::PH_MAGIC_P: begin
            if (b != pbm_pkg::CH_P) begin
              err_d = 1'b1;
              res_valid_o = 1'b1;
              res_o.kind = pbm_pkg::KIND_ERROR;
              res_o.error_code = pbm_pkg::ERR_MAGIC;
            end else begin
              phase_d = pbm_pkg::PH_MAGIC_4;
            end
          end
          pbm_pkg::PH_MAGIC_4: begin
            if (b != pbm_pkg::CH_FOUR) begin
              err_d = 1'b1;
              res_valid_o = 1'b1;
              res_o.kind = pbm_pkg::KIND_ERROR;
              res_o.error_code = pbm_pkg::ERR_MAGIC;
            end else begin
              phase_d = pbm_pkg::PH_SPACE;
              after_d = pbm_pkg::PH_WIDTH;
              seen_d  = 1'b0;
            end
          end
          pbm_pkg::PH_SPACE, pbm_pkg::PH_WIDTH, pbm_pkg::PH_HEIGHT: begin
            if ((phase_q == pbm_pkg::PH_SPACE) && pbm_pkg::is_ws(b)) begin
              seen_d = 1'b1;
            end else if ((phase_q == pbm_pkg::PH_SPACE) && !seen_q) begin
              err_d = 1'b1;
              res_valid_o = 1'b1;
              res_o.kind = pbm_pkg::KIND_ERROR;
              res_o.error_code = pbm_pkg::ERR_CHAR;
            end else begin
              seen_d  = 1'b0;
              phase_d = num_ph;
              if (pbm_pkg::is_digit(b)) begin
                acc_d  = (prod > PROD_W'(pbm_pkg::ACC_CAP)) ? ACC_W'(pbm_pkg::ACC_CAP)
                                                            : prod[ACC_W-1:0];
                have_d = 1'b1;
              end else if (!have_in || !pbm_pkg::is_ws(b)) begin
                err_d = 1'b1;
                res_valid_o = 1'b1;
                res_o.kind = pbm_pkg::KIND_ERROR;
                res_o.error_code = pbm_pkg::ERR_CHAR;
              end else begin
                acc_d  = '0;
                have_d = 1'b0;
                if (num_ph == pbm_pkg::PH_WIDTH) begin
                  if ((acc_in == '0) || (acc_in > ACC_W'(MAX_WIDTH))) begin
                    err_d = 1'b1;
                    res_valid_o = 1'b1;
                    res_o.kind = pbm_pkg::KIND_ERROR;
                    res_o.error_code = pbm_pkg::ERR_DIM;
                  end else begin
                    width_d = acc_in[WW-1:0];
                    phase_d = pbm_pkg::PH_SPACE;
                    after_d = pbm_pkg::PH_HEIGHT;
                    seen_d  = 1'b1;
                  end
                end else begin
                  if ((acc_in == '0) || (acc_in > ACC_W'(MAX_HEIGHT))) begin
                    err_d = 1'b1;
                    res_valid_o = 1'b1;
                    res_o.kind = pbm_pkg::KIND_ERROR;
                    res_o.error_code = pbm_pkg::ERR_DIM;
                  end else begin
                    height_d = acc_in[HW-1:0];
                    phase_d  = pbm_pkg::PH_RASTER;
                    row_d    = '0;
                    col_d    = '0;
                    res_valid_o = 1'b1;
                    res_o.kind = pbm_pkg::KIND_HEADER;
                    res_o.image_width  = w32[pbm_pkg::DIM_W-1:0];
                    res_o.image_height = 13'(acc_in);
                  end
                end
              end
            end
          end
          pbm_pkg::PH_RASTER: begin
            res_valid_o = 1'b1;
            res_o.kind = pbm_pkg::KIND_PIXELS;
            res_o.image_width  = w32[pbm_pkg::DIM_W-1:0];
            res_o.image_height = h32[pbm_pkg::DIM_W-1:0];
            res_o.pixel_bits   = b & mask;
            res_o.pixel_count  = cnt;
            res_o.row          = r32[pbm_pkg::POS_W-1:0];
            res_o.column       = c32[pbm_pkg::POS_W-1:0];
            res_o.last         = lst;
            if (col_next >= {1'b0, width_q}) begin
              col_d = '0;
              row_d = row_next[HW-1:0];
            end else begin
              col_d = col_next[WW-1:0];
            end
            fin_d = lst;
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

endmodule

// ----- src/pbm_out_stage.sv -----
// result register in front of the result channel
module pbm_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  input  pbm_pkg::res_t res_i,
  output logic          can_take_o,
  output logic          valid_o,
  output pbm_pkg::res_t res_o,
  input  logic          ready_i
);

  logic          valid_q, valid_d;
  pbm_pkg::res_t res_q;

  assign can_take_o = !valid_q || ready_i;
  assign valid_d    = can_take_o ? res_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_take_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- bench/tb.sv -----
// self-checking testbench for the pbm p4 stream parser: directed header, random raster
`timescale 1ns / 1ps

module tb;

  localparam int unsigned IMG_W        = 4093;
  localparam int unsigned IMG_H        = 3;
  localparam int          N_DIRECTED   = 25;
  localparam int          N_RASTER_RND = 3 * 512 - 6;
  localparam int          N_NOISE      = 60;
  localparam int          N_TOTAL      = N_DIRECTED + N_RASTER_RND + N_NOISE;
  localparam int          PH1_AT       = 555;
  localparam int          PH2_AT       = 1085;
  localparam int          HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [7:0]    b;
    logic          typed;
    pbm_pkg::res_t r;
  } row_t;

  function automatic row_t raw_row(input logic [7:0] b);
    row_t t;
    t = '0;
    t.b = b;
    return t;
  endfunction

  function automatic row_t hdr_row(input logic [7:0] b);
    row_t t;
    t = '0;
    t.b = b;
    t.typed = 1'b1;
    t.r.kind = pbm_pkg::KIND_HEADER;
    t.r.error_code = pbm_pkg::ERR_NONE;
    t.r.image_width = 13'(IMG_W);
    t.r.image_height = 13'(IMG_H);
    return t;
  endfunction

  function automatic row_t pix_row(input logic [7:0] b, input int unsigned col);
    row_t t;
    t = hdr_row(b);
    t.r.kind = pbm_pkg::KIND_PIXELS;
    t.r.pixel_bits = b;
    t.r.pixel_count = 4'd8;
    t.r.column = 12'(col);
    return t;
  endfunction

  // width 4093 is split by a comment, all six whitespace bytes appear in the header
  localparam row_t DIRECTED [N_DIRECTED] = '{
    raw_row(pbm_pkg::CH_P), raw_row(pbm_pkg::CH_FOUR), raw_row(pbm_pkg::CH_SP),
    raw_row(pbm_pkg::CH_HASH), raw_row(pbm_pkg::CH_HASH), raw_row(pbm_pkg::CH_LF),
    raw_row(pbm_pkg::CH_TAB), raw_row(pbm_pkg::CH_ZERO), raw_row(pbm_pkg::CH_FOUR),
    raw_row(pbm_pkg::CH_HASH), raw_row("x"), raw_row(pbm_pkg::CH_CR),
    raw_row(pbm_pkg::CH_ZERO), raw_row(pbm_pkg::CH_NINE), raw_row("3"), raw_row(8'h0B),
    raw_row(8'h0C), raw_row("3"), hdr_row(pbm_pkg::CH_CR),
    pix_row(pbm_pkg::CH_LF, 0), pix_row(pbm_pkg::CH_HASH, 8), pix_row(8'hFF, 16),
    pix_row(8'h00, 24), pix_row(8'h80, 32), pix_row(8'h01, 40)
  };

  localparam logic [7:0] ODD_BYTES [6] = '{
    8'h00, 8'hFF, pbm_pkg::CH_HASH, pbm_pkg::CH_LF, pbm_pkg::CH_CR, pbm_pkg::CH_SP
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  pbm_byte_if byte_if ();
  pbm_res_if  res_if ();

  pbm_p4_stream_parser_top u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .byte_i(byte_if),
    .res_o (res_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // parser state mirror
  pbm_pkg::phase_e ph        = pbm_pkg::PH_MAGIC_P;
  pbm_pkg::phase_e resume_ph = pbm_pkg::PH_MAGIC_P;
  pbm_pkg::phase_e after_ph  = pbm_pkg::PH_MAGIC_P;
  bit              seen_sp   = 1'b0;
  bit              have_dig  = 1'b0;
  bit              err_seen  = 1'b0;
  bit              img_done  = 1'b0;
  int unsigned     acc       = 0;
  int unsigned     wid       = 0;
  int unsigned     hgt       = 0;
  int unsigned     r_pos     = 0;
  int unsigned     c_pos     = 0;

  pbm_pkg::res_t pending_res [$];
  int   mismatches  = 0;
  int   src_idle    = 37;
  int   snk_idle    = 66;
  bit   stall_kick  = 1'b0;
  int   stall_left  = 0;

  function automatic bit raise(input pbm_pkg::err_e e, output pbm_pkg::res_t r);
    err_seen = 1'b1;
    r = '0;
    r.kind = pbm_pkg::KIND_ERROR;
    r.error_code = e;
    return 1'b1;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output pbm_pkg::res_t r);
    int unsigned v, left, cnt, mask;
    bit ws, dig, lst;
    r = '0;
    ws = (b == pbm_pkg::CH_SP) || (b >= pbm_pkg::CH_TAB && b <= pbm_pkg::CH_CR);
    dig = (b >= pbm_pkg::CH_ZERO) && (b <= pbm_pkg::CH_NINE);
    if (err_seen || img_done) return 1'b0;
    if (ph != pbm_pkg::PH_RASTER && b == pbm_pkg::CH_HASH) begin
      if (ph != pbm_pkg::PH_COMMENT) begin
        resume_ph = ph;
        ph = pbm_pkg::PH_COMMENT;
      end
      return 1'b0;
    end
    case (ph)
      pbm_pkg::PH_COMMENT: begin
        if (b == pbm_pkg::CH_LF || b == pbm_pkg::CH_CR) ph = resume_ph;
        return 1'b0;
      end
      pbm_pkg::PH_MAGIC_P: begin
        if (b != pbm_pkg::CH_P) return raise(pbm_pkg::ERR_MAGIC, r);
        ph = pbm_pkg::PH_MAGIC_4;
        return 1'b0;
      end
      pbm_pkg::PH_MAGIC_4: begin
        if (b != pbm_pkg::CH_FOUR) return raise(pbm_pkg::ERR_MAGIC, r);
        ph = pbm_pkg::PH_SPACE;
        after_ph = pbm_pkg::PH_WIDTH;
        seen_sp = 1'b0;
        return 1'b0;
      end
      pbm_pkg::PH_SPACE: begin
        if (ws) begin
          seen_sp = 1'b1;
          return 1'b0;
        end
        if (!seen_sp) return raise(pbm_pkg::ERR_CHAR, r);
        seen_sp = 1'b0;
        ph = after_ph;
        acc = 0;
        have_dig = 1'b0;
      end
      pbm_pkg::PH_RASTER: begin
        left = (wid > c_pos) ? wid - c_pos : 1;
        cnt = (left < 8) ? left : 8;
        mask = (32'hFF00 >> cnt) & 32'hFF;
        lst = (r_pos + 1 >= hgt) && (c_pos + cnt >= wid);
        r.kind = pbm_pkg::KIND_PIXELS;
        r.image_width = 13'(wid);
        r.image_height = 13'(hgt);
        r.pixel_bits = b & mask[7:0];
        r.pixel_count = 4'(cnt);
        r.row = 12'(r_pos);
        r.column = 12'(c_pos);
        r.last = lst;
        c_pos += cnt;
        if (c_pos >= wid) begin
          c_pos = 0;
          r_pos++;
        end
        if (lst) img_done = 1'b1;
        return 1'b1;
      end
      pbm_pkg::PH_WIDTH, pbm_pkg::PH_HEIGHT: ;
      default: return 1'b0;
    endcase
    // number digits and terminator
    if (dig) begin
      v = acc * 10 + (b - pbm_pkg::CH_ZERO);
      acc = (v > pbm_pkg::ACC_CAP) ? pbm_pkg::ACC_CAP : v;
      have_dig = 1'b1;
      return 1'b0;
    end
    if (!have_dig || !ws) return raise(pbm_pkg::ERR_CHAR, r);
    v = acc;
    acc = 0;
    have_dig = 1'b0;
    if (ph == pbm_pkg::PH_WIDTH) begin
      if (v == 0 || v > pbm_pkg::MAX_WIDTH_DEF) return raise(pbm_pkg::ERR_DIM, r);
      wid = v;
      ph = pbm_pkg::PH_SPACE;
      after_ph = pbm_pkg::PH_HEIGHT;
      seen_sp = 1'b1;
      return 1'b0;
    end
    if (v == 0 || v > pbm_pkg::MAX_HEIGHT_DEF) return raise(pbm_pkg::ERR_DIM, r);
    hgt = v;
    ph = pbm_pkg::PH_RASTER;
    r_pos = 0;
    c_pos = 0;
    r.kind = pbm_pkg::KIND_HEADER;
    r.image_width = 13'(wid);
    r.image_height = 13'(hgt);
    return 1'b1;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic typed,
                           input pbm_pkg::res_t typed_r);
    pbm_pkg::res_t r;
    bit got;
    while ($urandom_range(0, 99) < src_idle) begin
      byte_if.valid = 1'b0;
      @(negedge clk_i);
    end
    byte_if.valid = 1'b1;
    byte_if.byte_value = b;
    do @(posedge clk_i); while (!byte_if.ready);
    got = parse_byte(b, r);
    if (typed) begin
      got = 1'b1;
      r = typed_r;
    end
    if (got) pending_res.push_back(r);
    @(negedge clk_i);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  initial begin : stimulus
    logic [7:0] b;
    logic [2:0] k;
    int n;
    byte_if.valid = 1'b0;
    byte_if.byte_value = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    for (n = 0; n < N_TOTAL; n++) begin
      if (n == PH1_AT) begin
        byte_if.valid = 1'b0;
        while (pending_res.size() != 0) @(negedge clk_i);
        src_idle = 66;
        snk_idle = 37;
      end
      if (n == PH2_AT) begin
        src_idle = 0;
        snk_idle = 0;
        stall_kick = 1'b1;
      end
      if (n < N_DIRECTED) begin
        push_byte(DIRECTED[5'(n)].b, DIRECTED[5'(n)].typed, DIRECTED[5'(n)].r);
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          k = 3'($urandom_range(0, 5));
          b = ODD_BYTES[k];
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        push_byte(b, 1'b0, '0);
      end
    end
    byte_if.valid = 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : receiver
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_kick) begin
        stall_kick = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready = 1'b0;
      end else begin
        res_if.ready = ($urandom_range(0, 99) >= snk_idle);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    pbm_pkg::res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_res.size() == 0) begin
        $error("result beat with nothing expected: kind %0d", res_if.kind);
        mismatches++;
      end else begin
        want = pending_res.pop_front();
        cmp_field("kind", 32'(want.kind), 32'(res_if.kind));
        cmp_field("error_code", 32'(want.error_code), 32'(res_if.error_code));
        cmp_field("image_width", 32'(want.image_width), 32'(res_if.image_width));
        cmp_field("image_height", 32'(want.image_height), 32'(res_if.image_height));
        cmp_field("pixel_bits", 32'(want.pixel_bits), 32'(res_if.pixel_bits));
        cmp_field("pixel_count", 32'(want.pixel_count), 32'(res_if.pixel_count));
        cmp_field("row", 32'(want.row), 32'(res_if.row));
        cmp_field("column", 32'(want.column), 32'(res_if.column));
        cmp_field("last", 32'(want.last), 32'(res_if.last));
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
src/pbm_pkg.sv
src/pbm_if.sv
src/pbm_in_stage.sv
src/pbm_parse.sv
src/pbm_out_stage.sv
src/pbm_p4_stream_parser_top.sv
bench/tb.sv
